/* sv/sorted_set_insert_rotate_assert.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_SET_INSERT_ROTATE_ASSERT_SVH
`define SORTED_SET_INSERT_ROTATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSIR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssir assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssir assertion failed");

`endif

/* sv/ssir_pkg.sv */
`default_nettype none
package ssir_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;
    localparam int AMT_W    = 16;
    localparam int AIX_W    = $clog2(AMT_W);
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 5;
    localparam int STAT_W   = 3;
    localparam int OCC_W    = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ROTATE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ROTATED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_READ_OK  = 3'd4;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd5;

    typedef logic signed [VAL_W-1:0] t_elem;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic signed [VAL_W-1:0] value;
        logic [AMT_W-1:0]    amount;
        logic [INDEX_W-1:0]  index;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic signed [VAL_W-1:0] element;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_LEFT,
        CMD_RIGHT
    } t_cell_cmd;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cell_flags;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } t_rem_stat;

endpackage
`default_nettype wire

/* sv/ssir_if.sv */
`default_nettype none
interface ssir_in_if import ssir_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ssir_out_if import ssir_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/ssir_cell.sv */
`default_nettype none
module ssir_cell import ssir_pkg::*; (
    input  logic        i_clk,
    input  t_cell_cmd   i_cmd,
    input  t_elem       i_key,
    input  t_elem       i_left,
    input  t_elem       i_right,
    output t_elem       o_data,
    output t_cell_flags o_flags
);

    t_elem       r_data;
    t_elem       n_data;
    t_cell_flags r_flags;

    always_comb begin
        unique case (i_cmd)
            CMD_HOLD:  n_data = r_data;
            CMD_LOAD:  n_data = i_key;
            CMD_LEFT:  n_data = i_left;
            CMD_RIGHT: n_data = i_right;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        // compared against the held key; stable while the scan walks
        r_flags.gt <= (r_data > i_key);
        r_flags.eq <= (r_data == i_key);
    end

    assign o_data  = r_data;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

/* sv/ssir_rem.sv */
`default_nettype none
module ssir_rem import ssir_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AMT_W-1:0] i_amount,
    input  logic [CNT_W-1:0] i_divisor,
    output t_rem_stat        o_stat
);

    // restoring remainder, one dividend bit per cycle
    logic             r_busy;
    logic             r_done;
    logic [AIX_W-1:0] r_cnt;
    logic [AMT_W-1:0] r_num;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;

    assign w_trial = {r_rem, r_num[AMT_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == AIX_W'(AMT_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == AIX_W'(AMT_W - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_amount;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[AMT_W-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (w_trial >= {1'b0, i_divisor}) begin
                r_rem <= w_diff[CNT_W-1:0];
            end else begin
                r_rem <= w_trial[CNT_W-1:0];
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule
`default_nettype wire

/* sv/sorted_set_insert_rotate.sv */
// channel   dir  handshake      payload
// i_in_ch   in   valid/ready    op, value, amount, index
// o_out_ch  out  valid/ready    status, element, occupancy
//
// Read and unused op: the result register is loaded at accept.
// Insert: compare, then scan up to the stop point pos (at most count), then shift;
// a duplicate or a full set goes from the scan straight to done with no shift.
// Rotate: 16-step remainder unit, then amount mod count single-place rotations
// of the cell row, one per cycle; none with count < 2 or a zero remainder.
// Reset clears count, state and output valid; stored entries are not cleared.
// A stalled output holds one result; the next transaction is taken meanwhile.
`default_nettype none
module sorted_set_insert_rotate import ssir_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    ssir_in_if.sink    i_in_ch,
    ssir_out_if.source o_out_ch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_REM   = 3'd4;
    localparam logic [2:0] S_ROT   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_steps;
    t_elem             r_key;
    logic [STAT_W-1:0] r_res_status;
    t_elem             r_res_elem;
    logic              r_out_valid;
    t_out_item         r_out_item;

    t_elem       w_data  [CAPACITY];
    t_elem       w_left  [CAPACITY];
    t_elem       w_right [CAPACITY];
    t_cell_flags w_flags [CAPACITY];
    t_cell_cmd   w_cmd   [CAPACITY];

    logic        w_accept;
    logic        w_done_fire;
    logic        w_rem_start;
    logic        w_rd_ok;
    logic        w_scan_stop;
    t_cell_flags w_cur;
    t_rem_stat   w_rem;
    t_in_item    w_in;

    assign w_in        = i_in_ch.data;
    assign w_accept    = i_in_ch.valid && (r_state == S_IDLE);
    assign w_done_fire = (r_state == S_DONE) && (!r_out_valid || o_out_ch.ready);
    assign w_rem_start = w_accept && (w_in.op == OP_ROTATE) && (r_count >= CNT_W'(2));
    assign w_rd_ok     = (32'(w_in.index) < 32'(r_count));
    assign w_cur       = w_flags[r_pos[IDX_W-1:0]];
    assign w_scan_stop = (r_pos >= r_count) || w_cur.gt;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign w_left[gi] = r_key;
            end else begin : g_mid
                assign w_left[gi] = w_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right[gi] = w_data[0];
            end else begin : g_inner
                // last occupied cell wraps around to the front entry
                assign w_right[gi] = (CNT_W'(gi + 1) == r_count) ? w_data[0]
                                                                 : w_data[gi+1];
            end

            always_comb begin
                if (r_state == S_SHIFT) begin
                    if (CNT_W'(gi) == r_pos) begin
                        w_cmd[gi] = CMD_LOAD;
                    end else if (CNT_W'(gi) > r_pos) begin
                        w_cmd[gi] = CMD_LEFT;
                    end else begin
                        w_cmd[gi] = CMD_HOLD;
                    end
                end else if (r_state == S_ROT) begin
                    w_cmd[gi] = CMD_RIGHT;
                end else begin
                    w_cmd[gi] = CMD_HOLD;
                end
            end

            ssir_cell u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd[gi]),
                .i_key   (r_key),
                .i_left  (w_left[gi]),
                .i_right (w_right[gi]),
                .o_data  (w_data[gi]),
                .o_flags (w_flags[gi])
            );
        end
    endgenerate

    ssir_rem u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rem_start),
        .i_amount  (w_in.amount),
        .i_divisor (r_count),
        .o_stat    (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_in.op == OP_INSERT) begin
                            r_state <= S_CMP;
                        end else if (w_rem_start) begin
                            r_state <= S_REM;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CMP: r_state <= S_SCAN;
                S_SCAN: begin
                    if (w_scan_stop) begin
                        r_state <= (r_count >= CNT_W'(CAPACITY)) ? S_DONE : S_SHIFT;
                    end else if (w_cur.eq) begin
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_REM: begin
                    if (w_rem.done) begin
                        r_state <= (w_rem.rem == '0) ? S_DONE : S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_steps == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_done_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_in.value;
            r_pos <= '0;
            unique case (w_in.op)
                OP_INSERT: begin
                    r_res_status <= ST_INSERTED;
                    r_res_elem   <= '0;
                end
                OP_ROTATE: begin
                    r_res_status <= ST_ROTATED;
                    r_res_elem   <= '0;
                end
                OP_READ: begin
                    if (w_rd_ok) begin
                        r_res_status <= ST_READ_OK;
                        r_res_elem   <= w_data[IDX_W'(w_in.index)];
                    end else begin
                        r_res_status <= ST_RANGE;
                        r_res_elem   <= '0;
                    end
                end
                default: begin
                    r_res_status <= ST_RANGE;
                    r_res_elem   <= '0;
                end
            endcase
        end
        if (r_state == S_SCAN) begin
            if (w_scan_stop) begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    r_res_status <= ST_FULL;
                end
            end else if (w_cur.eq) begin
                r_res_status <= ST_DUP;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
        if ((r_state == S_REM) && w_rem.done) begin
            r_steps <= w_rem.rem;
        end else if (r_state == S_ROT) begin
            r_steps <= r_steps - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_fire) begin
            r_out_item.status    <= r_res_status;
            r_out_item.element   <= r_res_elem;
            r_out_item.occupancy <= OCC_W'(r_count);
        end
    end

    assign i_in_ch.ready  = (r_state == S_IDLE);
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out_item;

endmodule
`default_nettype wire

/* sv/ssir_checker.sv */
`default_nettype none
`include "sorted_set_insert_rotate_assert.svh"
module ssir_checker import ssir_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    logic w_out_stall;
    logic w_out_other;
    logic w_in_fire;

    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_out_other = i_out_valid && (i_out_item.status != ST_READ_OK);
    assign w_in_fire   = i_in_valid && i_in_ready;

    `SSIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(i_out_item))
    `SSIR_ASSERT_NOW(a_status_range, i_clk, i_rst_n, i_out_valid, i_out_item.status <= ST_RANGE)
    `SSIR_ASSERT_NOW(a_elem_zero, i_clk, i_rst_n, w_out_other, i_out_item.element == '0)
    `SSIR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !i_in_ready)

endmodule

bind sorted_set_insert_rotate ssir_checker u_ssir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_item  (o_out_ch.data)
);
`default_nettype wire

/* test/testbench.sv */
module testbench import ssir_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // op code 3 has no meaning in the block; it must answer with a range status
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned TAIL_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        t_in_item    item;
        int unsigned send_idle;
        int unsigned recv_idle;
        bit          drain_first;
        bit          long_hold;
    } t_queued_op;

    logic i_clk;
    logic i_rst_n;

    ssir_in_if  in_ch ();
    ssir_out_if out_ch ();

    sorted_set_insert_rotate DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    t_queued_op  ops_to_send[$];
    t_out_item   results_due[$];

    // shadow of the ordered set
    t_elem       set_store [CAPACITY];
    int unsigned set_count = 0;

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned recv_idle_pct = 60;
    int unsigned hold_left     = 0;
    bit          hold_trigger  = 1'b0;

    // settings applied to ops as they are queued
    int unsigned ph_send_idle = 22;
    int unsigned ph_recv_idle = 60;
    bit          ph_drain     = 1'b0;
    bit          ph_hold      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_set_op(t_in_item it);
        t_out_item   res;
        t_elem       v;
        t_elem       rot_tmp [CAPACITY];
        int unsigned pos;
        int unsigned r;
        bit          dup;
        res = '0;
        v   = it.value;
        case (it.op)
            OP_INSERT: begin
                pos = 0;
                dup = 1'b0;
                // scan stops at the first greater element; an equal one later is missed
                while (!dup && pos < set_count && set_store[pos] <= v) begin
                    if (set_store[pos] == v)
                        dup = 1'b1;
                    else
                        pos++;
                end
                if (dup) begin
                    res.status = ST_DUP;
                end else if (set_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = set_count; i > pos; i--)
                        set_store[i] = set_store[i-1];
                    set_store[pos] = v;
                    set_count++;
                    res.status = ST_INSERTED;
                end
            end
            OP_ROTATE: begin
                if (set_count >= 2) begin
                    r = it.amount % set_count;
                    for (int i = 0; i < set_count; i++)
                        rot_tmp[i] = set_store[(i + r) % set_count];
                    for (int i = 0; i < set_count; i++)
                        set_store[i] = rot_tmp[i];
                end
                res.status = ST_ROTATED;
            end
            OP_READ: begin
                if (it.index < set_count) begin
                    res.element = set_store[it.index];
                    res.status  = ST_READ_OK;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            default: res.status = ST_RANGE;
        endcase
        res.occupancy = OCC_W'(set_count);
        return res;
    endfunction

    task automatic queue_op(logic [OP_W-1:0] op, t_elem value,
                            logic [AMT_W-1:0] amount, logic [INDEX_W-1:0] index);
        t_queued_op q;
        q.item.op     = op;
        q.item.value  = value;
        q.item.amount = amount;
        q.item.index  = index;
        q.send_idle   = ph_send_idle;
        q.recv_idle   = ph_recv_idle;
        q.drain_first = ph_drain;
        q.long_hold   = ph_hold;
        ops_to_send.push_back(q);
        ph_drain = 1'b0;
        ph_hold  = 1'b0;
    endtask

    task automatic queue_random_op();
        int unsigned      pick;
        logic [OP_W-1:0]  op;
        t_elem            v;
        logic [AMT_W-1:0] a;
        pick = $urandom_range(99);
        if (pick < 30)
            op = OP_INSERT;
        else if (pick < 60)
            op = OP_ROTATE;
        else if (pick < 95)
            op = OP_READ;
        else
            op = OP_UNUSED;
        // a narrow pool makes duplicates common
        case ($urandom_range(3))
            0: v = t_elem'(int'($urandom_range(16)) - 8);
            1: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom;
        endcase
        case ($urandom_range(3))
            0: a = AMT_W'($urandom_range(40));
            1: a = $urandom_range(1) ? 16'hffff : 16'h0000;
            default: a = AMT_W'($urandom);
        endcase
        queue_op(op, v, a, INDEX_W'($urandom_range(31)));
    endtask

    initial begin
        i_rst_n = 1'b0;

        // empty set, short rotation, unused op
        queue_op(OP_READ,   0, 0, 0);
        queue_op(OP_ROTATE, 0, 5, 0);
        queue_op(OP_UNUSED, -1, 16'hffff, 31);
        queue_op(OP_INSERT, 0, 0, 0);
        queue_op(OP_ROTATE, 0, 16'hffff, 0);
        queue_op(OP_READ,   0, 0, 0);
        // extremes, duplicate, fill in the middle
        queue_op(OP_INSERT, 32'h8000_0000, 0, 0);
        queue_op(OP_INSERT, 32'h7fff_ffff, 0, 0);
        queue_op(OP_INSERT, 0, 0, 0);
        queue_op(OP_INSERT, -1, 0, 0);
        queue_op(OP_INSERT, 1, 0, 0);
        queue_op(OP_READ,   0, 0, 0);
        queue_op(OP_READ,   0, 0, 4);
        queue_op(OP_READ,   0, 0, 5);
        queue_op(OP_READ,   0, 0, 31);
        // after a rotation the scan can stop before an existing equal value
        queue_op(OP_ROTATE, 0, 2, 0);
        queue_op(OP_INSERT, -1, 0, 0);
        queue_op(OP_INSERT, 0, 0, 0);
        queue_op(OP_ROTATE, 0, 16'hffff, 0);
        queue_op(OP_ROTATE, 0, 0, 0);
        queue_op(OP_ROTATE, 0, 6, 0);
        queue_op(OP_READ,   0, 0, 5);
        queue_op(OP_INSERT, 32'h7fff_ffff, 0, 0);
        queue_op(OP_UNUSED, 0, 0, 0);

        for (int n = 0; n < 150; n++)
            queue_random_op();

        ph_send_idle = 60;
        ph_recv_idle = 22;
        ph_drain     = 1'b1;
        for (int n = 0; n < 150; n++)
            queue_random_op();

        ph_send_idle = 0;
        ph_recv_idle = 0;
        ph_drain     = 1'b1;
        for (int n = 0; n < 150; n++) begin
            if (n == 20)
                ph_hold = 1'b1;
            queue_random_op();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (ops_to_send.size() != 0 || in_ch.valid || results_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin : feed_proc
        t_queued_op nxt;
        bit         go;
        go = 1'b0;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            hold_trigger <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (ops_to_send.size() != 0) begin
                nxt = ops_to_send[0];
                // a drain point waits until every result so far has come back
                go  = (!nxt.drain_first || (!in_ch.valid && results_due.size() == 0))
                      && ($urandom_range(99) >= nxt.send_idle);
            end
            if (go) begin
                ops_to_send.delete(0);
                in_ch.data    <= nxt.item;
                in_ch.valid   <= 1'b1;
                recv_idle_pct <= nxt.recv_idle;
                hold_trigger  <= nxt.long_hold;
            end else begin
                in_ch.valid  <= 1'b0;
                hold_trigger <= 1'b0;
            end
        end else begin
            hold_trigger <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_trigger) begin
            out_ch.ready <= 1'b0;
            hold_left    <= LONG_HOLD;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (results_due.size() == 0) begin
                    $error("unexpected transaction: status %0d element %0d occupancy %0d",
                           got.status, got.element, got.occupancy);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.element !== want.element) begin
                        $error("element: expected %0d, got %0d", want.element, got.element);
                        mismatches++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                results_due.push_back(predict_set_op(in_ch.data));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

/* sim.f */
+incdir+sv
sv/ssir_pkg.sv
sv/ssir_if.sv
sv/ssir_cell.sv
sv/ssir_rem.sv
sv/sorted_set_insert_rotate.sv
sv/ssir_checker.sv
test/testbench.sv
